### rtl/core/bco_pkg.sv
// ----------------------------------------------------------------------------
// Balance controller package
// Widths, limits and register indexes shared by the balance controller.
// ----------------------------------------------------------------------------
package bco_pkg;

    localparam int unsigned ACC_W  = 56;   // product accumulator width
    localparam int unsigned DIV_W  = 42;   // dividend and quotient width
    localparam int unsigned DEN_W  = 21;   // divisor width

    localparam logic [16:0] ENGAGE_WINDOW = 17'd1280;  // 5 degrees in Q8.8
    localparam logic [16:0] DROP_WINDOW   = 17'd3840;  // 15 degrees in Q8.8
    localparam logic [16:0] ODO_MIN_US    = 17'd100;
    localparam logic [DEN_W-1:0] US_PER_SECOND = 21'd1000000;
    localparam logic [DIV_W-1:0] HALF_SECOND   = 42'd500000;
    localparam logic [23:0] SETTLE_MAX    = 24'hFFFFFF;

    localparam logic [3:0] REG_TARGET     = 4'd0;
    localparam logic [3:0] REG_ANGLE_GAIN = 4'd1;
    localparam logic [3:0] REG_RATE_GAIN  = 4'd2;
    localparam logic [3:0] REG_POS_GAIN   = 4'd3;
    localparam logic [3:0] REG_SPEED_GAIN = 4'd4;
    localparam logic [3:0] REG_FAST_BW    = 4'd5;
    localparam logic [3:0] REG_SLOW_BW    = 4'd6;
    localparam logic [3:0] REG_SETTLE     = 4'd7;

    typedef logic signed [ACC_W-1:0] t_acc;

endpackage

### rtl/core/balance_controller_with_odometry.sv
// ----------------------------------------------------------------------------
// Balance controller with odometry
// State-feedback balance controller with speed filters and position estimate.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. Each tick is worked through by a single
// shift-and-add multiplier, one multiplier bit per cycle, and a restoring
// divider, one quotient bit per cycle. An engaged tick runs the four command
// terms through the multiplier; a tick that advances the odometry adds two
// filter steps and a position step, each a multiply and then a divide. Input
// is taken only while the sequencer is idle; the result sits in an output
// register, so the next tick may be accepted while a finished result still
// waits downstream. Configuration writes are always taken and should only be
// issued while no tick is in flight.
// ----------------------------------------------------------------------------
module balance_controller_with_odometry
    import bco_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_tilt_angle,
    input  logic signed [15:0] i_tilt_rate,
    input  logic [15:0]        i_elapsed_us,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_speed_command,
    output logic               o_engaged,
    output logic signed [31:0] o_position_out,
    output logic signed [15:0] o_slow_speed_out
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_CMD  = 4'd2;
    localparam logic [3:0] S_ODO  = 4'd3;
    localparam logic [3:0] S_FSET = 4'd4;
    localparam logic [3:0] S_DSET = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_UPD  = 4'd7;
    localparam logic [3:0] S_PSET = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    localparam logic [1:0] PH_TERM = 2'd0;
    localparam logic [1:0] PH_FILT = 2'd1;
    localparam logic [1:0] PH_POS  = 2'd2;

    localparam logic [5:0] MUL_LAST = 6'd16;
    localparam logic [5:0] DIV_LAST = 6'(DIV_W - 1);

    // Configuration registers.
    logic signed [15:0] r_target, r_angle_gain, r_rate_gain, r_pos_gain, r_speed_gain;
    logic [19:0]        r_fast_bw, r_slow_bw;
    logic [23:0]        r_settle_time;

    // Controller state.
    logic               r_engaged;
    logic [23:0]        r_settle_cnt;
    logic [16:0]        r_odo_acc;
    logic signed [15:0] r_fast, r_slow;
    logic signed [31:0] r_pos;

    // Sequencer and serial units.
    logic [3:0]         r_state;
    logic [1:0]         r_phase;
    logic [1:0]         r_term;
    logic               r_sel;
    logic [5:0]         r_cnt;
    t_acc               r_macc, r_mcand;
    logic [16:0]        r_mplier;
    logic               r_mtop_neg;
    logic               r_neg;
    logic [DIV_W-1:0]   r_dnd;
    logic [DEN_W-1:0]   r_rem, r_den;
    logic signed [15:0] r_rate, r_cmd;
    logic               r_odo_go;
    logic [16:0]        r_dt;

    logic               r_out_valid;
    logic signed [15:0] r_out_cmd, r_out_slow;
    logic               r_out_eng;
    logic signed [31:0] r_out_pos;

    // Accept-time decisions.
    logic               w_accept;
    logic signed [16:0] w_err;
    logic [16:0]        w_aerr;
    logic               w_in_win, w_in_drop;
    logic [24:0]        w_settle_sum;
    logic [23:0]        w_settle_sat;
    logic               w_eng_now, w_active;
    logic [16:0]        w_odo_sum;

    assign w_accept     = i_in_valid && o_in_ready;
    assign w_err        = 17'(r_target) - 17'(i_tilt_angle);
    assign w_aerr       = w_err[16] ? 17'(-w_err) : 17'(w_err);
    assign w_in_win     = w_aerr <= ENGAGE_WINDOW;
    assign w_in_drop    = w_aerr <= DROP_WINDOW;
    assign w_settle_sum = {1'b0, r_settle_cnt} + {9'd0, i_elapsed_us};
    assign w_settle_sat = w_settle_sum[24] ? SETTLE_MAX : w_settle_sum[23:0];
    assign w_eng_now    = r_engaged || (w_in_win && (w_settle_sat > r_settle_time));
    assign w_active     = w_eng_now && w_in_drop;
    assign w_odo_sum    = r_odo_acc + {1'b0, i_elapsed_us};

    // Operands of the next command term.
    logic [1:0]         w_nterm;
    logic signed [32:0] w_negpos;
    logic signed [32:0] w_perr;
    t_acc               w_tm_mcand;
    logic [16:0]        w_tm_gain;

    assign w_nterm  = r_term + 2'd1;
    assign w_negpos = -33'(r_pos);

    always_comb begin
        if (w_negpos > 33'sd16777216) begin
            w_perr = 33'sd16777216;
        end else if (w_negpos < -33'sd16777216) begin
            w_perr = -33'sd16777216;
        end else begin
            w_perr = w_negpos;
        end
        unique case (w_nterm)
            2'd1: begin
                w_tm_mcand = -(ACC_W'(r_rate) <<< 16);
                w_tm_gain  = 17'(r_rate_gain);
            end
            2'd2: begin
                w_tm_mcand = ACC_W'(w_perr);
                w_tm_gain  = 17'(r_pos_gain);
            end
            2'd3: begin
                w_tm_mcand = -(ACC_W'(r_slow) <<< 10);
                w_tm_gain  = 17'(r_speed_gain);
            end
            default: begin
                w_tm_mcand = '0;
                w_tm_gain  = '0;
            end
        endcase
    end

    // Rounding and clamping of the command sum.
    t_acc               w_rnd;
    logic signed [15:0] w_cmd_clamped;

    assign w_rnd = (r_macc + t_acc'(64'sd2097152)) >>> 22;

    always_comb begin
        if (w_rnd > t_acc'(64'sd16384)) begin
            w_cmd_clamped = 16'sd16384;
        end else if (w_rnd < t_acc'(-64'sd16384)) begin
            w_cmd_clamped = -16'sd16384;
        end else begin
            w_cmd_clamped = w_rnd[15:0];
        end
    end

    // Filter operands.
    logic signed [15:0] w_fsel;
    logic signed [17:0] w_diff;
    logic [DEN_W-1:0]   w_fden;

    assign w_fsel = r_sel ? r_slow : r_fast;
    assign w_diff = 18'(r_cmd) - 18'(w_fsel);
    assign w_fden = DEN_W'(r_sel ? r_slow_bw : r_fast_bw) + DEN_W'(r_dt);

    // Divider step.
    logic [DEN_W:0] w_rs;
    logic           w_ge;

    assign w_rs = {r_rem, r_dnd[DIV_W-1]};
    assign w_ge = w_rs >= {1'b0, r_den};

    // Result updates.
    logic signed [18:0] w_fq, w_fnew;
    logic signed [24:0] w_pq;
    logic signed [33:0] w_pnew;
    logic signed [31:0] w_psat;

    assign w_fq   = r_neg ? -19'(r_dnd[17:0]) : 19'(r_dnd[17:0]);
    assign w_fnew = 19'(w_fsel) + w_fq;
    assign w_pq   = r_neg ? -25'(r_dnd[23:0]) : 25'(r_dnd[23:0]);
    assign w_pnew = 34'(r_pos) + 34'(w_pq);

    always_comb begin
        if (w_pnew > 34'sd2147483647) begin
            w_psat = 32'sh7FFFFFFF;
        end else if (w_pnew < -34'sd2147483648) begin
            w_psat = 32'sh80000000;
        end else begin
            w_psat = w_pnew[31:0];
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target      <= 16'sd640;
            r_angle_gain  <= 16'sd819;
            r_rate_gain   <= 16'sd0;
            r_pos_gain    <= -16'sd1024;
            r_speed_gain  <= -16'sd8192;
            r_fast_bw     <= 20'd50000;
            r_slow_bw     <= 20'd250000;
            r_settle_time <= 24'd1000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TARGET:     r_target      <= i_cfg_data[15:0];
                REG_ANGLE_GAIN: r_angle_gain  <= i_cfg_data[15:0];
                REG_RATE_GAIN:  r_rate_gain   <= i_cfg_data[15:0];
                REG_POS_GAIN:   r_pos_gain    <= i_cfg_data[15:0];
                REG_SPEED_GAIN: r_speed_gain  <= i_cfg_data[15:0];
                REG_FAST_BW:    r_fast_bw     <= i_cfg_data[19:0];
                REG_SLOW_BW:    r_slow_bw     <= i_cfg_data[19:0];
                REG_SETTLE:     r_settle_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_engaged    <= 1'b0;
            r_settle_cnt <= '0;
            r_odo_acc    <= '0;
            r_fast       <= '0;
            r_slow       <= '0;
            r_pos        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // A finished tick loads the output register once it is free.
            if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        // The settle timer only runs while disengaged inside the window.
                        if (!r_engaged && w_in_win && !(w_settle_sat > r_settle_time)) begin
                            r_settle_cnt <= w_settle_sat;
                        end else begin
                            r_settle_cnt <= '0;
                        end
                        r_engaged <= w_active;
                        r_rate    <= i_tilt_rate;
                        if (w_odo_sum >= ODO_MIN_US) begin
                            r_odo_go  <= 1'b1;
                            r_dt      <= w_odo_sum;
                            r_odo_acc <= '0;
                        end else begin
                            r_odo_go  <= 1'b0;
                            r_dt      <= w_odo_sum;
                            r_odo_acc <= w_odo_sum;
                        end
                        if (w_active) begin
                            r_phase    <= PH_TERM;
                            r_term     <= 2'd0;
                            r_cnt      <= '0;
                            r_macc     <= '0;
                            r_mcand    <= ACC_W'(w_err) <<< 16;
                            r_mplier   <= 17'(r_angle_gain);
                            r_mtop_neg <= 1'b1;
                            r_state    <= S_MUL;
                        end else begin
                            // A tick that is not active (disengaged or dropping out) clears every estimate.
                            r_cmd   <= '0;
                            r_fast  <= '0;
                            r_slow  <= '0;
                            r_pos   <= '0;
                            r_state <= S_ODO;
                        end
                    end
                end
                S_MUL: begin
                    if (r_mplier[0]) begin
                        if (r_cnt == MUL_LAST && r_mtop_neg) begin
                            r_macc <= r_macc - r_mcand;
                        end else begin
                            r_macc <= r_macc + r_mcand;
                        end
                    end
                    if (r_cnt == MUL_LAST) begin
                        r_cnt <= '0;
                        if (r_phase != PH_TERM) begin
                            r_state <= S_DSET;
                        end else if (r_term == 2'd3) begin
                            r_state <= S_CMD;
                        end else begin
                            r_term   <= w_nterm;
                            r_mcand  <= w_tm_mcand;
                            r_mplier <= w_tm_gain;
                        end
                    end else begin
                        r_mcand  <= r_mcand <<< 1;
                        r_mplier <= r_mplier >> 1;
                        r_cnt    <= r_cnt + 6'd1;
                    end
                end
                S_CMD: begin
                    r_cmd   <= w_cmd_clamped;
                    r_state <= S_ODO;
                end
                S_ODO: begin
                    r_sel   <= 1'b0;
                    r_state <= r_odo_go ? S_FSET : S_OUT;
                end
                S_FSET: begin
                    r_phase    <= PH_FILT;
                    r_neg      <= w_diff[17];
                    r_mcand    <= w_diff[17] ? ACC_W'(-w_diff) : ACC_W'(w_diff);
                    r_mplier   <= r_dt;
                    r_mtop_neg <= 1'b0;
                    r_macc     <= '0;
                    r_cnt      <= '0;
                    r_den      <= w_fden;
                    r_state    <= S_MUL;
                end
                S_PSET: begin
                    r_phase    <= PH_POS;
                    r_neg      <= r_fast[15];
                    r_mcand    <= (r_fast[15] ? ACC_W'(-17'(r_fast)) : ACC_W'(r_fast)) <<< 10;
                    r_mplier   <= r_dt;
                    r_mtop_neg <= 1'b0;
                    r_macc     <= '0;
                    r_cnt      <= '0;
                    r_den      <= US_PER_SECOND;
                    r_state    <= S_MUL;
                end
                S_DSET: begin
                    // Adding half the divisor gives round to nearest on the magnitude.
                    if (r_phase == PH_POS) begin
                        r_dnd <= r_macc[DIV_W-1:0] + HALF_SECOND;
                    end else begin
                        r_dnd <= r_macc[DIV_W-1:0] + DIV_W'(r_den >> 1);
                    end
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_ge ? DEN_W'(w_rs - {1'b0, r_den}) : w_rs[DEN_W-1:0];
                    r_dnd <= {r_dnd[DIV_W-2:0], w_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (r_phase == PH_POS) begin
                        r_pos   <= w_psat;
                        r_state <= S_OUT;
                    end else if (!r_sel) begin
                        r_fast  <= w_fnew[15:0];
                        r_sel   <= 1'b1;
                        r_state <= S_FSET;
                    end else begin
                        r_slow  <= w_fnew[15:0];
                        r_state <= S_PSET;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_cmd   <= r_cmd;
                        r_out_eng   <= r_engaged;
                        r_out_pos   <= r_pos;
                        r_out_slow  <= r_slow;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_speed_command  = r_out_cmd;
    assign o_engaged        = r_out_eng;
    assign o_position_out   = r_out_pos;
    assign o_slow_speed_out = r_out_slow;

endmodule
